// ----- rtl/mrc_pkg.sv -----
// shared types, constants and codes of the modbus rtu request checker
`timescale 1ns / 1ps

package mrc_pkg;

    // frame buffer geometry
    localparam int BUFFER_DEPTH    = 128;
    localparam int MAX_WRITE_WORDS = 64;
    localparam int ADDR_W          = $clog2(BUFFER_DEPTH);
    localparam int LEN_W           = $clog2(BUFFER_DEPTH + 1);
    localparam int MIN_FRAME       = 8;

    // crc-16 constants
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // function codes
    localparam logic [7:0] FN_READ       = 8'h03;
    localparam logic [7:0] FN_WRITE_ONE  = 8'h06;
    localparam logic [7:0] FN_WRITE_MANY = 8'h10;

    // input kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_POLL = 1'b1;

    // configuration register indexes
    localparam logic CFG_SLAVE_ADDRESS   = 1'b0;
    localparam logic CFG_READ_WORD_LIMIT = 1'b1;

    // status codes
    localparam logic [2:0] ST_READ_OK     = 3'd0;
    localparam logic [2:0] ST_WRITE_ONE   = 3'd1;
    localparam logic [2:0] ST_WRITE_MANY  = 3'd2;
    localparam logic [2:0] ST_CRC_ERROR   = 3'd3;
    localparam logic [2:0] ST_BAD_LENGTH  = 3'd4;
    localparam logic [2:0] ST_OTHER_FN    = 3'd5;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  function_code;
        logic [15:0] start_address;
        logic [15:0] count_or_value;
        logic [7:0]  declared_bytes;
        logic [7:0]  frame_length;
    } t_rsp;

endpackage

// ----- rtl/mrc_ram.sv -----
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module mrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/mrc_crc.sv -----
// modbus crc-16 accumulator, one byte per cycle while i_en is high
`timescale 1ns / 1ps

module mrc_crc
    import mrc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_init,
    input  logic        i_en,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);

    logic [15:0] r_crc;
    logic [15:0] n_crc;

    // eight reflected shift steps over one byte
    always_comb begin
        logic [15:0] v;
        v = r_crc ^ {8'h00, i_byte};
        for (int b = 0; b < 8; b++) begin
            if (v[0]) begin
                v = (v >> 1) ^ CRC_POLY;
            end else begin
                v = v >> 1;
            end
        end
        n_crc = v;
    end

    always_ff @(posedge i_clk) begin
        if (i_init) begin
            r_crc <= CRC_INIT;
        end else if (i_en) begin
            r_crc <= n_crc;
        end
    end

    assign o_crc = r_crc;

endmodule

// ----- rtl/modbus_rtu_request_checker_unit.sv -----
// top level of the modbus rtu request checker
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------
//  in      | input     | i_in_valid / o_in_ready | i_in_data  (t_req)
//  out     | output    | o_out_valid/i_out_ready | o_out_data (t_rsp)
//  cfg     | input     | i_cfg_we                | i_cfg_index, i_cfg_data
//
// a received byte is written into the frame ram at the fill count; on a full buffer
// it is dropped and the fill count cleared. a poll with n >= 8 buffered bytes walks
// the frame, one ram read per cycle feeding the byte-wide crc unit, and the status
// is decided in the fin state. an address mismatch ends the walk after the first byte.
// reset (synchronous, active low) clears the fill count, the sequencer and the output.
// a finished request waits in the output register; bytes are taken meanwhile, and a
// further poll holds in its decision cycle until the output register is free.
`timescale 1ns / 1ps

module modbus_rtu_request_checker_unit
    import mrc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_req       i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_rsp       o_out_data,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_rd_idx, n_rd_idx;
    logic [LEN_W-1:0] r_dat_idx;
    logic             r_dat_vld;
    logic [7:0]       r_slave_address;
    logic [6:0]       r_read_word_limit;
    logic [7:0]       r_fn;
    logic [15:0]      r_addr;
    logic [15:0]      r_cnt;
    logic [7:0]       r_bc;
    logic [15:0]      r_crc_rx;
    logic             r_out_valid;
    t_rsp             r_out;

    logic             in_acc;
    logic             ram_we, ram_re;
    logic [7:0]       ram_rdata;
    logic             crc_init, crc_en;
    logic [15:0]      crc_val;
    logic [LEN_W-1:0] last_idx, crc_lo_idx;
    logic             out_free, out_load;
    logic [2:0]       status;
    logic [16:0]      twice_cnt;
    logic [17:0]      len_need;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign out_load   = (r_state == S_FIN) && out_free;
    assign last_idx   = r_len - LEN_W'(1);
    assign crc_lo_idx = r_len - LEN_W'(2);

    // frame storage
    assign ram_we = in_acc && (i_in_data.kind == KIND_BYTE) && (r_len < LEN_W'(BUFFER_DEPTH));
    assign ram_re = (r_state == S_READ) && (r_rd_idx < r_len);

    mrc_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_len[ADDR_W-1:0]),
        .i_wdata (i_in_data.rx_byte),
        .i_re    (ram_re),
        .i_raddr (r_rd_idx[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // crc over every byte before the trailing crc pair
    assign crc_init = in_acc && (i_in_data.kind == KIND_POLL);
    assign crc_en   = (r_state == S_READ) && r_dat_vld && (r_dat_idx < crc_lo_idx);

    mrc_crc u_crc (
        .i_clk  (i_clk),
        .i_init (crc_init),
        .i_en   (crc_en),
        .i_byte (ram_rdata),
        .o_crc  (crc_val)
    );

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_len    = r_len;
        n_rd_idx = r_rd_idx;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.kind == KIND_BYTE) begin
                        if (r_len < LEN_W'(BUFFER_DEPTH)) begin
                            n_len = r_len + LEN_W'(1);
                        end else begin
                            n_len = '0;
                        end
                    end else if (r_len >= LEN_W'(MIN_FRAME)) begin
                        n_state  = S_READ;
                        n_rd_idx = '0;
                    end
                end
            end
            S_READ: begin
                if (ram_re) begin
                    n_rd_idx = r_rd_idx + LEN_W'(1);
                end
                if (r_dat_vld) begin
                    if (r_dat_idx == '0 && ram_rdata != r_slave_address) begin
                        n_state = S_IDLE;
                        n_len   = '0;
                    end else if (r_dat_idx == last_idx) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                    n_len   = '0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_len     <= '0;
            r_rd_idx  <= '0;
            r_dat_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_len     <= n_len;
            r_rd_idx  <= n_rd_idx;
            r_dat_vld <= ram_re;
        end
    end

    // index of the byte arriving from the ram
    always_ff @(posedge i_clk) begin
        if (ram_re) begin
            r_dat_idx <= r_rd_idx;
        end
    end

    // capture decoded header fields and received crc
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ && r_dat_vld) begin
            if (r_dat_idx == LEN_W'(1)) r_fn <= ram_rdata;
            if (r_dat_idx == LEN_W'(2)) r_addr[15:8] <= ram_rdata;
            if (r_dat_idx == LEN_W'(3)) r_addr[7:0] <= ram_rdata;
            if (r_dat_idx == LEN_W'(4)) r_cnt[15:8] <= ram_rdata;
            if (r_dat_idx == LEN_W'(5)) r_cnt[7:0] <= ram_rdata;
            if (r_dat_idx == LEN_W'(6)) r_bc <= ram_rdata;
            if (r_dat_idx == crc_lo_idx) r_crc_rx[7:0] <= ram_rdata;
            if (r_dat_idx == last_idx) r_crc_rx[15:8] <= ram_rdata;
        end
    end

    // status decision
    assign twice_cnt = {r_cnt, 1'b0};
    assign len_need  = 18'd9 + {1'b0, twice_cnt};

    always_comb begin
        if (r_crc_rx != crc_val) begin
            status = ST_CRC_ERROR;
        end else if (r_fn == FN_READ) begin
            status = (r_cnt != 16'd0 && r_cnt <= {9'd0, r_read_word_limit})
                   ? ST_READ_OK : ST_BAD_LENGTH;
        end else if (r_fn == FN_WRITE_ONE) begin
            status = ST_WRITE_ONE;
        end else if (r_fn == FN_WRITE_MANY) begin
            if (r_cnt != 16'd0 && r_cnt <= 16'(MAX_WRITE_WORDS)
                && 18'(r_len) >= len_need && {9'd0, r_bc} == twice_cnt) begin
                status = ST_WRITE_MANY;
            end else begin
                status = ST_BAD_LENGTH;
            end
        end else begin
            status = ST_OTHER_FN;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.status         <= status;
            r_out.function_code  <= r_fn;
            r_out.start_address  <= r_addr;
            r_out.count_or_value <= r_cnt;
            r_out.declared_bytes <= r_bc;
            r_out.frame_length   <= 8'(r_len);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_address   <= 8'd1;
            r_read_word_limit <= 7'd64;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SLAVE_ADDRESS:   r_slave_address   <= i_cfg_data;
                CFG_READ_WORD_LIMIT: r_read_word_limit <= i_cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

endmodule

// ----- rtl/mrc_checker.sv -----
// port level assertions for the modbus rtu request checker, with bind
`timescale 1ns / 1ps

module mrc_checker
    import mrc_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_rsp o_out_data
);

    // a stalled request holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("request changed while stalled");

    // reset empties the output
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // status and function agree
    a_read_fn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ST_READ_OK || o_out_data.status == ST_WRITE_ONE
        || o_out_data.status == ST_WRITE_MANY) |->
        (o_out_data.status != ST_READ_OK || o_out_data.function_code == FN_READ) &&
        (o_out_data.status != ST_WRITE_ONE || o_out_data.function_code == FN_WRITE_ONE) &&
        (o_out_data.status != ST_WRITE_MANY || o_out_data.function_code == FN_WRITE_MANY))
        else $error("status does not match function code");

    // accepted write multiple declares two bytes per word
    a_many_bc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_WRITE_MANY |->
        o_out_data.declared_bytes == {o_out_data.count_or_value[6:0], 1'b0})
        else $error("write multiple byte count mismatch");

    // status stays within its codes
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.status <= ST_OTHER_FN)
        else $error("status out of range");

endmodule

bind modbus_rtu_request_checker_unit mrc_checker u_mrc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
